// ===== hdl/thsched_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer heap scheduler package
// Shared types, command and status codes for the timer queue.
// ----------------------------------------------------------------------------
package thsched_pkg;

   localparam int NUM_TIMERS_DEF = 16;
   localparam int TIME_BITS_DEF  = 48;
   localparam int TAG_BITS_DEF   = 16;

   localparam int KIND_W   = 3;
   localparam int ID_W     = 4;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;
   localparam int WAIT_W   = 32;
   localparam int OTAG_W   = 16;

   // command kinds
   localparam logic [KIND_W-1:0] KIND_SCHEDULE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CANCEL   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EXPIRE   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_WAIT     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FLUSH    = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_SCHEDULED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CANCEL_NONE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CANCELLED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EXPIRED     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FLUSHED     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NONE_EXP    = 3'd5;
   localparam logic [STATUS_W-1:0] ST_WAIT        = 3'd6;
   localparam logic [STATUS_W-1:0] ST_FLUSH_EMPTY = 3'd7;

   // per-cell sift command broadcast by the controller
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_SWAP
   } cell_op_type;

endpackage

// ===== hdl/thsched_cell.sv =====
// ----------------------------------------------------------------------------
// Timer heap cell
// One heap entry (deadline and slot). Loads a word, or trades its word with
// the partner position chosen by the controller.
// ----------------------------------------------------------------------------
module thsched_cell #(
   parameter int TIME_BITS = thsched_pkg::TIME_BITS_DEF,
   parameter int SLOT_W    = 4
) (
   input  logic                         clock,
   input  thsched_pkg::cell_op_type     op,
   input  logic [TIME_BITS-1:0]         load_deadline,
   input  logic [SLOT_W-1:0]            load_slot,
   output logic [TIME_BITS-1:0]         deadline,
   output logic [SLOT_W-1:0]            slot
);

   logic [TIME_BITS-1:0] deadline_ff;
   logic [SLOT_W-1:0]    slot_ff;

   // take a new word on load or swap, hold otherwise
   always_ff @(posedge clock) begin
      case (op)
         thsched_pkg::CELL_LOAD,
         thsched_pkg::CELL_SWAP: begin
            deadline_ff <= load_deadline;
            slot_ff     <= load_slot;
         end
         default: begin
            deadline_ff <= deadline_ff;
            slot_ff     <= slot_ff;
         end
      endcase
   end

   assign deadline = deadline_ff;
   assign slot     = slot_ff;

endmodule

// ===== hdl/timer_heap_scheduler.sv =====
// ----------------------------------------------------------------------------
// Timer heap scheduler
// Binary min-heap timer queue with a newest-first active list.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Busy drops in the
// cycle that shows the last result of the command, so the next command can be
// taken in that cycle. Each result sits on the rsp_ ports for one cycle,
// marked by rsp_valid, and the receiver cannot stall it. The time that a
// command runs depends on how many heap levels its sift walks, one level
// per cycle:
// - a wait query, a cancel of an idle timer and a schedule of an active timer
//   are answered from idle, with the result registered at acceptance;
// - a schedule of an idle timer loads the new entry at the heap end and sifts
//   it up;
// - a cancel moves the last heap entry into the hole and sifts it up or down,
//   with no sift when the timer held the last heap entry;
// - an expire with nothing due shows a single none-expired result; otherwise
//   each due timer is removed as in a cancel and shown, until none is due;
// - a flush shows one result per cycle from the head of the active list,
//   and an empty flush shows a single flush-empty result.
// The heap lives in a row of cells, one per entry; a sift step swaps two
// cells chosen by the controller.
// ----------------------------------------------------------------------------
module timer_heap_scheduler #(
   parameter int NUM_TIMERS = thsched_pkg::NUM_TIMERS_DEF,
   parameter int TIME_BITS  = thsched_pkg::TIME_BITS_DEF,
   parameter int TAG_BITS   = thsched_pkg::TAG_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [thsched_pkg::KIND_W-1:0]       req_kind,
   input  logic [thsched_pkg::ID_W-1:0]         req_timer_id,
   input  logic [TIME_BITS-1:0]                 req_deadline,
   input  logic [TAG_BITS-1:0]                  req_op_tag,
   input  logic [TIME_BITS-1:0]                 req_now,
   output logic                                 rsp_valid,
   output logic [thsched_pkg::STATUS_W-1:0]     rsp_status,
   output logic [thsched_pkg::ID_W-1:0]         rsp_result_timer,
   output logic [thsched_pkg::OTAG_W-1:0]       rsp_result_tag,
   output logic                                 rsp_is_first,
   output logic signed [thsched_pkg::WAIT_W-1:0] rsp_wait_msec,
   output logic [thsched_pkg::COUNT_W-1:0]      rsp_active_count,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic signed [thsched_pkg::WAIT_W-1:0] csr_max_wait
);

   localparam int PW = $clog2(NUM_TIMERS);      // heap / slot index width
   localparam int CW = $clog2(NUM_TIMERS + 1);  // count width
   localparam int LW = $clog2(NUM_TIMERS + 1);  // list link width (with null)
   localparam logic [LW-1:0] NIL = LW'(NUM_TIMERS);
   localparam logic [CW-1:0] FULL = CW'(NUM_TIMERS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCHED_UP,
      S_DEL_FIX,
      S_DEL_UP,
      S_DEL_DOWN,
      S_DEL_DONE,
      S_EXPIRE_CHK,
      S_FLUSH
   } state_type;

   // cell row
   thsched_pkg::cell_op_type cell_op [NUM_TIMERS];
   logic [TIME_BITS-1:0] cell_dl_in [NUM_TIMERS];
   logic [PW-1:0]        cell_sl_in [NUM_TIMERS];
   logic [TIME_BITS-1:0] cell_dl [NUM_TIMERS];
   logic [PW-1:0]        cell_sl [NUM_TIMERS];

   // slot tables
   logic [NUM_TIMERS-1:0] active_ff;
   logic [PW-1:0]         pos_ff  [NUM_TIMERS];
   logic [TAG_BITS-1:0]   tag_ff  [NUM_TIMERS];
   logic [LW-1:0]         next_ff [NUM_TIMERS];
   logic [LW-1:0]         prev_ff [NUM_TIMERS];
   logic [LW-1:0]         head_ff;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         left_ff;

   state_type            state_ff;
   logic [PW-1:0]        idx_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [PW-1:0]        slot_ff;
   logic [TAG_BITS-1:0]  rtag_ff;
   logic signed [thsched_pkg::WAIT_W-1:0] max_wait_ff;

   logic                                 rv_ff;
   logic [thsched_pkg::STATUS_W-1:0]     rst_ff;
   logic [thsched_pkg::ID_W-1:0]         rtm_ff;
   logic [thsched_pkg::OTAG_W-1:0]       rtg_ff;
   logic                                 rfirst_ff;
   logic signed [thsched_pkg::WAIT_W-1:0] rwait_ff;
   logic [thsched_pkg::COUNT_W-1:0]      rcnt_ff;
   logic                                 rlast_ff;

   genvar g;
   generate
      for (g = 0; g < NUM_TIMERS; g++) begin : g_cell
         thsched_cell #(.TIME_BITS(TIME_BITS), .SLOT_W(PW)) u_cell (
            .clock         (clock),
            .op            (cell_op[g]),
            .load_deadline (cell_dl_in[g]),
            .load_slot     (cell_sl_in[g]),
            .deadline      (cell_dl[g]),
            .slot          (cell_sl[g])
         );
      end
   endgenerate

   // slot addressed by the command word, and whether it exists
   logic [PW-1:0] req_slot;
   logic          id_ok;
   assign req_slot = PW'(req_timer_id);
   assign id_ok    = (int'(req_timer_id) < NUM_TIMERS);

   // sift helpers around the current index
   logic [PW:0]   par_w, lc_w, rc_w;
   logic [PW-1:0] par_i, lc_i, rc_i, m_i, last_i;
   logic          has_l, has_r, up_go, down_go, swap_up, swap_dn;
   logic [CW-1:0] cnt_m1;
   logic          due;
   logic [TIME_BITS-1:0] cur_dl;

   always_comb begin
      par_w  = ({1'b0, idx_ff} - (PW+1)'(1)) >> 1;
      lc_w   = {idx_ff, 1'b1};
      rc_w   = lc_w + (PW+1)'(1);
      par_i  = par_w[PW-1:0];
      lc_i   = lc_w[PW-1:0];
      rc_i   = rc_w[PW-1:0];
      cnt_m1 = count_ff - CW'(1);
      last_i = cnt_m1[PW-1:0];
      has_l  = lc_w < (PW+1)'(count_ff);
      has_r  = rc_w < (PW+1)'(count_ff);
      cur_dl = cell_dl[idx_ff];
      m_i    = (!has_r || (cell_dl[lc_i] < cell_dl[rc_i])) ? lc_i : rc_i;
      swap_up = (idx_ff != '0) && (cur_dl < cell_dl[par_i]);
      swap_dn = has_l && !(cur_dl < cell_dl[m_i]);
      up_go   = swap_up;
      down_go = swap_dn;
      due     = (count_ff != '0) && !(now_ff < cell_dl[0]);
   end

   logic accept;
   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;

   // cell commands: a swap between idx and a partner, or a load of idx
   logic [PW-1:0] pa_i;
   logic          do_swap, do_load, do_move;
   logic [PW-1:0] load_i;
   logic [TIME_BITS-1:0] load_dl;
   logic [PW-1:0] load_sl;

   always_comb begin
      do_swap = 1'b0;
      do_load = 1'b0;
      do_move = 1'b0;
      pa_i    = par_i;
      load_i  = '0;
      load_dl = req_deadline;
      load_sl = req_slot;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_kind == thsched_pkg::KIND_SCHEDULE && id_ok &&
                !active_ff[req_slot] && count_ff < FULL) begin
               do_load = 1'b1;
               load_i  = count_ff[PW-1:0];
            end
         end
         S_SCHED_UP, S_DEL_UP: begin
            do_swap = up_go;
            pa_i    = par_i;
         end
         S_DEL_DOWN: begin
            do_swap = down_go;
            pa_i    = m_i;
         end
         S_DEL_FIX: begin
            // move last entry into the hole
            do_move = (idx_ff != last_i);
            load_i  = idx_ff;
            load_dl = cell_dl[last_i];
            load_sl = cell_sl[last_i];
         end
         default: ;
      endcase
      for (int k = 0; k < NUM_TIMERS; k++) begin
         cell_op[k]    = thsched_pkg::CELL_HOLD;
         cell_dl_in[k] = load_dl;
         cell_sl_in[k] = load_sl;
         if ((do_load || do_move) && PW'(k) == load_i) begin
            cell_op[k] = thsched_pkg::CELL_LOAD;
         end else if (do_swap && PW'(k) == idx_ff) begin
            cell_op[k]    = thsched_pkg::CELL_SWAP;
            cell_dl_in[k] = cell_dl[pa_i];
            cell_sl_in[k] = cell_sl[pa_i];
         end else if (do_swap && PW'(k) == pa_i) begin
            cell_op[k]    = thsched_pkg::CELL_SWAP;
            cell_dl_in[k] = cur_dl;
            cell_sl_in[k] = cell_sl[idx_ff];
         end
      end
   end

   // sequencer, slot tables and result word
   always_ff @(posedge clock) begin
      rv_ff    <= 1'b0;
      rlast_ff <= 1'b0;
      if (reset) begin
         state_ff    <= S_IDLE;
         active_ff   <= '0;
         head_ff     <= NIL;
         count_ff    <= '0;
         max_wait_ff <= 32'sh7FFFFFFF;
      end else begin
         if (csr_valid && csr_ready) begin
            max_wait_ff <= csr_max_wait;
         end
         // keep slot positions in step with cell swaps
         if (do_swap) begin
            pos_ff[cell_sl[idx_ff]] <= pa_i;
            pos_ff[cell_sl[pa_i]]   <= idx_ff;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  now_ff         <= req_now;
                  slot_ff        <= req_slot;
                  rtm_ff         <= req_timer_id;
                  rtg_ff         <= '0;
                  rfirst_ff      <= 1'b0;
                  rwait_ff       <= '0;
                  rcnt_ff        <= thsched_pkg::COUNT_W'(count_ff);
                  if ((req_kind == thsched_pkg::KIND_SCHEDULE ||
                       req_kind == thsched_pkg::KIND_CANCEL) && !id_ok) begin
                     rv_ff    <= 1'b1;
                     rlast_ff <= 1'b1;
                     rst_ff   <= thsched_pkg::ST_CANCEL_NONE;
                  end else begin
                     case (req_kind)
                        thsched_pkg::KIND_SCHEDULE: begin
                           tag_ff[req_slot] <= req_op_tag;
                           if (do_load) begin
                              pos_ff[req_slot]  <= count_ff[PW-1:0];
                              count_ff <= count_ff + CW'(1);
                              idx_ff   <= count_ff[PW-1:0];
                              next_ff[req_slot] <= head_ff;
                              prev_ff[req_slot] <= NIL;
                              if (head_ff != NIL) begin
                                 prev_ff[head_ff[PW-1:0]] <= LW'(req_timer_id);
                              end
                              head_ff  <= LW'(req_timer_id);
                              active_ff[req_slot] <= 1'b1;
                              state_ff <= S_SCHED_UP;
                           end else begin
                              rv_ff     <= 1'b1;
                              rlast_ff  <= 1'b1;
                              rst_ff    <= thsched_pkg::ST_SCHEDULED;
                              rfirst_ff <= (pos_ff[req_slot] == '0);
                           end
                        end
                        thsched_pkg::KIND_CANCEL: begin
                           if (active_ff[req_slot]) begin
                              rtag_ff  <= tag_ff[req_slot];
                              idx_ff   <= pos_ff[req_slot];
                              rst_ff   <= thsched_pkg::ST_CANCELLED;
                              state_ff <= S_DEL_FIX;
                           end else begin
                              rv_ff    <= 1'b1;
                              rlast_ff <= 1'b1;
                              rst_ff   <= thsched_pkg::ST_CANCEL_NONE;
                           end
                        end
                        thsched_pkg::KIND_EXPIRE: begin
                           state_ff <= S_EXPIRE_CHK;
                        end
                        thsched_pkg::KIND_WAIT: begin
                           rv_ff    <= 1'b1;
                           rlast_ff <= 1'b1;
                           rst_ff   <= thsched_pkg::ST_WAIT;
                           rtm_ff   <= '0;
                           if (count_ff == '0) begin
                              rwait_ff <= max_wait_ff;
                           end else begin
                              rwait_ff <= thsched_pkg::WAIT_W'(64'(cell_dl[0]) -
                                                               64'(req_now));
                           end
                        end
                        thsched_pkg::KIND_FLUSH: begin
                           left_ff  <= count_ff;
                           state_ff <= S_FLUSH;
                        end
                        default: ;
                     endcase
                  end
               end
            end
            S_SCHED_UP: begin
               if (up_go) begin
                  idx_ff <= par_i;
               end else begin
                  rv_ff     <= 1'b1;
                  rlast_ff  <= 1'b1;
                  rst_ff    <= thsched_pkg::ST_SCHEDULED;
                  rfirst_ff <= (pos_ff[slot_ff] == '0);
                  rcnt_ff   <= thsched_pkg::COUNT_W'(count_ff);
                  state_ff  <= S_IDLE;
               end
            end
            S_DEL_FIX: begin
               // drop the entry at idx, fill from the end
               count_ff <= cnt_m1;
               if (idx_ff != last_i) begin
                  pos_ff[cell_sl[last_i]] <= idx_ff;
                  if (idx_ff != '0 && cell_dl[last_i] < cell_dl[par_i]) begin
                     state_ff <= S_DEL_UP;
                  end else begin
                     state_ff <= S_DEL_DOWN;
                  end
               end else begin
                  state_ff <= S_DEL_DONE;
               end
               // unlink from the active list
               if (head_ff == LW'(slot_ff)) begin
                  head_ff <= next_ff[slot_ff];
               end
               if (prev_ff[slot_ff] != NIL) begin
                  next_ff[prev_ff[slot_ff][PW-1:0]] <= next_ff[slot_ff];
               end
               if (next_ff[slot_ff] != NIL) begin
                  prev_ff[next_ff[slot_ff][PW-1:0]] <= prev_ff[slot_ff];
               end
               active_ff[slot_ff] <= 1'b0;
            end
            S_DEL_UP: begin
               if (up_go) begin
                  idx_ff <= par_i;
               end else begin
                  state_ff <= S_DEL_DONE;
               end
            end
            S_DEL_DOWN: begin
               if (down_go) begin
                  idx_ff <= m_i;
               end else begin
                  state_ff <= S_DEL_DONE;
               end
            end
            S_DEL_DONE: begin
               rv_ff   <= 1'b1;
               rtm_ff  <= thsched_pkg::ID_W'(slot_ff);
               rtg_ff  <= thsched_pkg::OTAG_W'(rtag_ff);
               rcnt_ff <= thsched_pkg::COUNT_W'(count_ff);
               if (rst_ff == thsched_pkg::ST_CANCELLED) begin
                  rlast_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  // expired entry shown; last if no more are due
                  rlast_ff <= !due;
                  state_ff <= due ? S_EXPIRE_CHK : S_IDLE;
               end
            end
            S_EXPIRE_CHK: begin
               if (due) begin
                  slot_ff  <= cell_sl[0];
                  rtag_ff  <= tag_ff[cell_sl[0]];
                  idx_ff   <= '0;
                  rst_ff   <= thsched_pkg::ST_EXPIRED;
                  state_ff <= S_DEL_FIX;
               end else begin
                  rv_ff    <= 1'b1;
                  rlast_ff <= 1'b1;
                  rst_ff   <= thsched_pkg::ST_NONE_EXP;
                  rtm_ff   <= '0;
                  rtg_ff   <= '0;
                  rcnt_ff  <= thsched_pkg::COUNT_W'(count_ff);
                  state_ff <= S_IDLE;
               end
            end
            S_FLUSH: begin
               rv_ff  <= 1'b1;
               if (head_ff == NIL) begin
                  rlast_ff <= 1'b1;
                  rst_ff   <= thsched_pkg::ST_FLUSH_EMPTY;
                  rtm_ff   <= '0;
                  rtg_ff   <= '0;
                  rcnt_ff  <= '0;
                  count_ff <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  rst_ff  <= thsched_pkg::ST_FLUSHED;
                  rtm_ff  <= thsched_pkg::ID_W'(head_ff[PW-1:0]);
                  rtg_ff  <= thsched_pkg::OTAG_W'(tag_ff[head_ff[PW-1:0]]);
                  rcnt_ff <= thsched_pkg::COUNT_W'((left_ff != '0) ?
                                                   left_ff - CW'(1) : left_ff);
                  if (left_ff != '0) begin
                     left_ff <= left_ff - CW'(1);
                  end
                  active_ff[head_ff[PW-1:0]] <= 1'b0;
                  next_ff[head_ff[PW-1:0]]   <= NIL;
                  prev_ff[head_ff[PW-1:0]]   <= NIL;
                  head_ff <= next_ff[head_ff[PW-1:0]];
                  if (next_ff[head_ff[PW-1:0]] == NIL) begin
                     rlast_ff <= 1'b1;
                     count_ff <= '0;
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rv_ff;
   assign rsp_status       = rst_ff;
   assign rsp_result_timer = rtm_ff;
   assign rsp_result_tag   = rtg_ff;
   assign rsp_is_first     = rfirst_ff;
   assign rsp_wait_msec    = rwait_ff;
   assign rsp_active_count = rcnt_ff;
   assign rsp_last         = rlast_ff;

endmodule

// ===== hdl/thsched_checker.sv =====
// ----------------------------------------------------------------------------
// Timer heap scheduler checker
// Port-level properties of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module thsched_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 rsp_valid,
   input logic                                 rsp_last,
   input logic [thsched_pkg::STATUS_W-1:0]     rsp_status,
   input logic [thsched_pkg::COUNT_W-1:0]      rsp_active_count
);

   // a last mark only rides on a shown word
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid) else $error("last without valid");

   // count never passes the slot total
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
      rsp_active_count <= thsched_pkg::COUNT_W'(thsched_pkg::NUM_TIMERS_DEF))
      else $error("active count out of range");

   // a flush-empty reply reports an empty queue and ends the command
   a_flush_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == thsched_pkg::ST_FLUSH_EMPTY |->
      rsp_last && rsp_active_count == '0) else $error("bad flush empty");

   // the closing word of a command is shown with the block idle again
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("busy after last");

   // a non-last word is followed by more work
   a_more: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy) else $error("early idle");

endmodule

bind timer_heap_scheduler thsched_checker u_thsched_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_last         (rsp_last),
   .rsp_status       (rsp_status),
   .rsp_active_count (rsp_active_count)
);
